### src/qrsm_pkg.sv
// Shared types, widths and register codes for the quadrotor speed mixer.
package qrsm_pkg;

   localparam int CMD_WIDTH       = 32;
   localparam int GAIN_WIDTH      = 28;
   localparam int SPEED_WIDTH     = 16;
   localparam int PROD_WIDTH      = GAIN_WIDTH + 1 + CMD_WIDTH;
   localparam int SUM_WIDTH       = PROD_WIDTH + 2;
   localparam int FRAC_BITS       = 24;
   localparam int ROOT_ARG_WIDTH  = 32;
   localparam int SQRT_STEPS      = ROOT_ARG_WIDTH / 2;
   localparam int REM_WIDTH       = SPEED_WIDTH + 2;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int LANES           = 4;
   localparam int MIX_STAGES      = 2;
   localparam int PIPE_STAGES     = MIX_STAGES + SQRT_STEPS + 1;

   localparam int LANE_FRONT = 0;
   localparam int LANE_REAR  = 1;
   localparam int LANE_LEFT  = 2;
   localparam int LANE_RIGHT = 3;

   typedef logic signed [CMD_WIDTH-1:0]  cmd_type;
   typedef logic [GAIN_WIDTH-1:0]        gain_type;
   typedef logic [SPEED_WIDTH-1:0]       speed_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [SUM_WIDTH-1:0]  sum_type;
   typedef logic [ROOT_ARG_WIDTH-1:0]    root_arg_type;
   typedef logic [REM_WIDTH-1:0]         rem_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ARM_GAIN       = 8'd0,
      CSR_YAW_GAIN       = 8'd1,
      CSR_THRUST_GAIN    = 8'd2,
      CSR_MOTORS_ENABLED = 8'd3
   } csr_index_type;

   localparam gain_type ARM_GAIN_RESET    = 28'd33675340;
   localparam gain_type YAW_GAIN_RESET    = 28'd3878788;
   localparam gain_type THRUST_GAIN_RESET = 28'd3535912;

   typedef struct packed {
      logic valid;
      logic enabled;
   } stage_ctl_type;

endpackage

### src/qrsm_if.sv
// Request and response channel interfaces of the quadrotor speed mixer.
interface qrsm_req_if import qrsm_pkg::*; ();
   logic    valid;
   logic    ready;
   cmd_type x_command;
   cmd_type y_command;
   cmd_type yaw_command;
   cmd_type thrust_command;

   modport source (output valid, x_command, y_command, yaw_command, thrust_command,
                   input ready);
   modport sink (input valid, x_command, y_command, yaw_command, thrust_command,
                 output ready);
endinterface

interface qrsm_rsp_if import qrsm_pkg::*; ();
   logic      valid;
   logic      ready;
   speed_type front_speed;
   speed_type rear_speed;
   speed_type left_speed;
   speed_type right_speed;

   modport source (output valid, front_speed, rear_speed, left_speed, right_speed,
                   input ready);
   modport sink (input valid, front_speed, rear_speed, left_speed, right_speed,
                 output ready);
endinterface

### src/qrsm_mix.sv
// Gain products, rotor mixing sums and integer-part clamp for all four lanes.
module qrsm_mix import qrsm_pkg::*; (
   input  logic         clock,
   input  logic         load_product,
   input  logic         load_sum,
   input  gain_type     arm_gain,
   input  gain_type     yaw_gain,
   input  gain_type     thrust_gain,
   input  cmd_type      x_command,
   input  cmd_type      y_command,
   input  cmd_type      yaw_command,
   input  cmd_type      thrust_command,
   output root_arg_type root_arg [LANES],
   output logic         below_one [LANES]
);

   prod_type     ax_ff, ay_ff, yt_ff, tt_ff;
   prod_type     ax_in, ay_in, yt_in, tt_in;
   sum_type      lane_sum [LANES];
   root_arg_type root_arg_ff [LANES];
   root_arg_type root_arg_in [LANES];
   logic         below_one_ff [LANES];
   logic         below_one_in [LANES];

   assign ax_in = $signed({1'b0, arm_gain}) * x_command;
   assign ay_in = $signed({1'b0, arm_gain}) * y_command;
   assign yt_in = $signed({1'b0, yaw_gain}) * yaw_command;
   assign tt_in = $signed({1'b0, thrust_gain}) * thrust_command;

   always_ff @(posedge clock) begin
      if (load_product) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         yt_ff <= yt_in;
         tt_ff <= tt_in;
      end
   end

   always_comb begin
      lane_sum[LANE_FRONT] = sum_type'(yt_ff) + sum_type'(tt_ff) - sum_type'(ay_ff);
      lane_sum[LANE_REAR]  = sum_type'(yt_ff) + sum_type'(tt_ff) + sum_type'(ay_ff);
      lane_sum[LANE_LEFT]  = sum_type'(tt_ff) - sum_type'(yt_ff) + sum_type'(ax_ff);
      lane_sum[LANE_RIGHT] = sum_type'(tt_ff) - sum_type'(yt_ff) - sum_type'(ax_ff);
      for (int l = 0; l < LANES; l++) begin
         below_one_in[l] = lane_sum[l][SUM_WIDTH-1] ||
                           (lane_sum[l][SUM_WIDTH-2:FRAC_BITS] == '0);
         if (|lane_sum[l][SUM_WIDTH-2:FRAC_BITS+ROOT_ARG_WIDTH]) begin
            root_arg_in[l] = '1;
         end else begin
            root_arg_in[l] = lane_sum[l][FRAC_BITS+ROOT_ARG_WIDTH-1:FRAC_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_sum) begin
         root_arg_ff  <= root_arg_in;
         below_one_ff <= below_one_in;
      end
   end

   assign root_arg  = root_arg_ff;
   assign below_one = below_one_ff;

endmodule

### src/qrsm_sqrt_lane.sv
// Pipelined integer square root, one result bit per stage, for one rotor lane.
module qrsm_sqrt_lane import qrsm_pkg::*; (
   input  logic                  clock,
   input  logic [SQRT_STEPS-1:0] advance,
   input  root_arg_type          arg,
   input  logic                  below_one_in,
   output speed_type             root,
   output logic                  below_one_out
);

   root_arg_type x_ff [SQRT_STEPS];
   root_arg_type x_in [SQRT_STEPS];
   rem_type      rem_ff [SQRT_STEPS];
   rem_type      rem_in [SQRT_STEPS];
   speed_type    root_ff [SQRT_STEPS];
   speed_type    root_in [SQRT_STEPS];
   logic         low_ff [SQRT_STEPS];
   logic         low_in [SQRT_STEPS];

   always_comb begin
      root_arg_type src_x;
      rem_type      src_rem;
      speed_type    src_root;
      logic         src_low;
      rem_type      partial;
      rem_type      trial;
      for (int s = 0; s < SQRT_STEPS; s++) begin
         if (s == 0) begin
            src_x    = arg;
            src_rem  = '0;
            src_root = '0;
            src_low  = below_one_in;
         end else begin
            src_x    = x_ff[s-1];
            src_rem  = rem_ff[s-1];
            src_root = root_ff[s-1];
            src_low  = low_ff[s-1];
         end
         partial = {src_rem[REM_WIDTH-3:0], src_x[ROOT_ARG_WIDTH-1 -: 2]};
         trial   = {src_root, 2'b01};
         x_in[s]   = {src_x[ROOT_ARG_WIDTH-3:0], 2'b00};
         low_in[s] = src_low;
         if (partial >= trial) begin
            rem_in[s]  = partial - trial;
            root_in[s] = {src_root[SPEED_WIDTH-2:0], 1'b1};
         end else begin
            rem_in[s]  = partial;
            root_in[s] = {src_root[SPEED_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < SQRT_STEPS; s++) begin
         if (advance[s]) begin
            x_ff[s]    <= x_in[s];
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            low_ff[s]  <= low_in[s];
         end
      end
   end

   assign root          = root_ff[SQRT_STEPS-1];
   assign below_one_out = low_ff[SQRT_STEPS-1];

endmodule

### src/qrsm_merge.sv
// Output register that combines the lane roots with the floor and enable rules.
module qrsm_merge import qrsm_pkg::*; (
   input  logic      clock,
   input  logic      load,
   input  logic      enabled,
   input  speed_type root [LANES],
   input  logic      below_one [LANES],
   output speed_type speed [LANES]
);

   speed_type speed_ff [LANES];
   speed_type speed_in [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (!enabled) begin
            speed_in[l] = '0;
         end else if (below_one[l]) begin
            speed_in[l] = speed_type'(1);
         end else begin
            speed_in[l] = root[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         speed_ff <= speed_in;
      end
   end

   assign speed = speed_ff;

endmodule

### src/quad_rotor_speed_mixer_unit.sv
// Top level of the quadrotor plus-frame speed mixer.
//
//   channel  direction  handshake        payload
//   req      in         valid / ready    x, y, yaw, thrust commands, Q16.16
//   rsp      out        valid / ready    front, rear, left, right speeds
//   csr      in         write enable     index, 28-bit data, write only
//
// The pipeline has two mixing stages, sixteen root stages and one output register.
// One request per cycle enters if not stalled; a stage holds only when full and the next holds.
// Reset loads the default gains, enables the motors and empties the pipeline.
// A stalled response backs up the pipeline; empty stages still take new requests.
module quad_rotor_speed_mixer_unit import qrsm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  gain_type                   csr_write_data,
   qrsm_req_if.sink                   req_port,
   qrsm_rsp_if.source                 rsp_port
);

   gain_type      arm_gain_ff, yaw_gain_ff, thrust_gain_ff;
   logic          motors_enabled_ff;
   stage_ctl_type ctl_ff [PIPE_STAGES];
   stage_ctl_type ctl_in [PIPE_STAGES];
   logic [PIPE_STAGES-1:0] advance;

   root_arg_type root_arg [LANES];
   logic         mix_below_one [LANES];
   speed_type    lane_root [LANES];
   logic         lane_below_one [LANES];
   speed_type    speed [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_gain_ff       <= ARM_GAIN_RESET;
         yaw_gain_ff       <= YAW_GAIN_RESET;
         thrust_gain_ff    <= THRUST_GAIN_RESET;
         motors_enabled_ff <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ARM_GAIN:       arm_gain_ff       <= csr_write_data;
            CSR_YAW_GAIN:       yaw_gain_ff       <= csr_write_data;
            CSR_THRUST_GAIN:    thrust_gain_ff    <= csr_write_data;
            CSR_MOTORS_ENABLED: motors_enabled_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
         if (k == PIPE_STAGES - 1) begin
            advance[k] = !ctl_ff[k].valid || rsp_port.ready;
         end else begin
            advance[k] = !ctl_ff[k].valid || advance[k+1];
         end
      end
      for (int k = 0; k < PIPE_STAGES; k++) begin
         if (k == 0) begin
            ctl_in[k].valid   = req_port.valid;
            ctl_in[k].enabled = motors_enabled_ff;
         end else begin
            ctl_in[k] = ctl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_STAGES; k++) begin
            ctl_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < PIPE_STAGES; k++) begin
            if (advance[k]) begin
               ctl_ff[k] <= ctl_in[k];
            end
         end
      end
   end

   assign req_port.ready = advance[0];
   assign rsp_port.valid = ctl_ff[PIPE_STAGES-1].valid;

   qrsm_mix u_mix (
      .clock          (clock),
      .load_product   (advance[0]),
      .load_sum       (advance[1]),
      .arm_gain       (arm_gain_ff),
      .yaw_gain       (yaw_gain_ff),
      .thrust_gain    (thrust_gain_ff),
      .x_command      (req_port.x_command),
      .y_command      (req_port.y_command),
      .yaw_command    (req_port.yaw_command),
      .thrust_command (req_port.thrust_command),
      .root_arg       (root_arg),
      .below_one      (mix_below_one)
   );

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      qrsm_sqrt_lane u_sqrt (
         .clock         (clock),
         .advance       (advance[MIX_STAGES +: SQRT_STEPS]),
         .arg           (root_arg[l]),
         .below_one_in  (mix_below_one[l]),
         .root          (lane_root[l]),
         .below_one_out (lane_below_one[l])
      );
   end

   qrsm_merge u_merge (
      .clock     (clock),
      .load      (advance[PIPE_STAGES-1]),
      .enabled   (ctl_ff[PIPE_STAGES-2].enabled),
      .root      (lane_root),
      .below_one (lane_below_one),
      .speed     (speed)
   );

   assign rsp_port.front_speed = speed[LANE_FRONT];
   assign rsp_port.rear_speed  = speed[LANE_REAR];
   assign rsp_port.left_speed  = speed[LANE_LEFT];
   assign rsp_port.right_speed = speed[LANE_RIGHT];

endmodule
